[design/hjn_pkg.sv]
// shared types and constants for the process cpu rate hash join
`timescale 1ns / 1ps
package hjn_pkg;

	localparam int MAX_ENTRIES  = 1024;
	localparam int NUM_BUCKETS  = 2048;
	localparam int ENTRY_BITS   = $clog2(MAX_ENTRIES);
	localparam int PTR_BITS     = $clog2(MAX_ENTRIES + 1);
	localparam int BUCKET_BITS  = $clog2(NUM_BUCKETS);

	localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;

	localparam logic [23:0] RATE_MAX  = 24'hFFFFFF;
	localparam int          DIV_STEPS = 24;

	localparam int                        CFG_INDEX_BITS = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ELAPSED    = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SNAPSHOTS  = 8'd1;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_CLEARED = 3'd1,
		ST_FULL    = 3'd2,
		ST_RATE    = 3'd3,
		ST_NO_RATE = 3'd4
	} status_e;

	typedef struct packed {
		op_e         operation;
		logic [30:0] process_id;
		logic [63:0] start_stamp;
		logic [63:0] cpu_time_ns;
	} item_t;

	typedef struct packed {
		status_e     status;
		logic [23:0] cpu_percent_q8;
	} result_t;

	typedef struct packed {
		item_t                  item;
		logic [BUCKET_BITS-1:0] bucket;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} qwr_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MIX,
		F_MUL,
		F_PUSH
	} front_state_e;

	typedef enum logic [3:0] {
		B_INIT,
		B_IDLE,
		B_HRD,
		B_HCHK,
		B_HVAL,
		B_WALK,
		B_CMP,
		B_DSET,
		B_DSAT,
		B_DIV,
		B_OUT
	} back_state_e;

endpackage

[design/process_cpu_rate_hash_join_unit.sv]
// top level of the process cpu rate hash join
// insert and query items are hashed on one 32x32 multiplier; an insert is not stored
// when the table is full; a query walks the bucket chain and runs the bit-serial rate
// divider unless the rate saturates or the query cannot give a rate; clear and nop skip
// the hash; the front takes one item at a time but can take a new one while the back
// still works on earlier ones if the two entry queue has room and results are drained
// after reset a pass clears all 2048 bucket heads; full stays high until it ends
`timescale 1ns / 1ps
module process_cpu_rate_hash_join_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  hjn_pkg::item_t                     item,
	output logic                               empty,
	input  logic                               pop,
	output hjn_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hjn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [63:0]                        cfg_data
);
	import hjn_pkg::*;

	logic front_idle, init_busy, q_full, q_empty, q_pop, take;
	qwr_t q_wr;
	cmd_t q_cmd;

	assign full      = !front_idle || init_busy;
	assign take      = push && !full;
	assign cfg_ready = 1'b1;

	hjn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.idle   (front_idle),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	hjn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.cmd    (q_cmd),
		.empty  (q_empty)
	);

	hjn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

[design/hjn_front.sv]
// front end: takes items and computes the bucket hash on a shared multiplier
`timescale 1ns / 1ps
module hjn_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  hjn_pkg::item_t item,
	output logic           idle,
	input  logic           q_full,
	output hjn_pkg::qwr_t  q_wr
);
	import hjn_pkg::*;

	front_state_e           state_q, state_d;
	item_t                  item_q;
	logic [63:0]            v_q, mp_q, acc_q;
	logic [1:0]             cnt_q;
	logic                   pass_q;
	logic [BUCKET_BITS-1:0] bucket_q;

	logic [63:0] id64, mix_sum, v1, v2, res, h, cst;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	always_comb begin
		id64    = {33'd0, item_q.process_id};
		mix_sum = item_q.start_stamp + MIX_ADD + (id64 << 6) + (id64 >> 2);
		v1      = id64 ^ mix_sum;
		v2      = v1 ^ (v1 >> 30);
		cst     = pass_q ? MIX_MUL2 : MIX_MUL1;
		mul_a   = (cnt_q == 2'd1) ? v_q[63:32] : v_q[31:0];
		mul_b   = (cnt_q == 2'd2) ? cst[63:32] : cst[31:0];
		mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
		res     = {acc_q[63:32] + mp_q[31:0], acc_q[31:0]};
		h       = res ^ (res >> 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (take) begin
					item_q <= item;
					pass_q <= 1'b0;
					cnt_q  <= 2'd0;
				end
			end
			F_MIX: begin
				v_q <= v2;
			end
			F_MUL: begin
				mp_q  <= mul_p;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd1) begin
					acc_q <= mp_q;
				end else if (cnt_q == 2'd2) begin
					acc_q[63:32] <= acc_q[63:32] + mp_q[31:0];
				end else if (cnt_q == 2'd3) begin
					if (!pass_q) begin
						v_q    <= res ^ (res >> 27);
						pass_q <= 1'b1;
					end else begin
						bucket_q <= h[BUCKET_BITS-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		q_wr.push  = 1'b0;
		q_wr.cmd   = '{item: item_q, bucket: bucket_q};
		idle       = (state_q == F_IDLE);
		unique case (state_q)
			F_IDLE: begin
				if (take) begin
					if (item.operation == OP_INSERT || item.operation == OP_QUERY) begin
						state_d = F_MIX;
					end else begin
						state_d = F_PUSH;
					end
				end
			end
			F_MIX: begin
				state_d = F_MUL;
			end
			F_MUL: begin
				if (cnt_q == 2'd3 && pass_q) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					q_wr.push = 1'b1;
					state_d   = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

endmodule

[design/hjn_queue.sv]
// two entry command queue between front and back
`timescale 1ns / 1ps
module hjn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  hjn_pkg::qwr_t wr,
	output logic          full,
	input  logic          pop,
	output hjn_pkg::cmd_t cmd,
	output logic          empty
);
	import hjn_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign cmd     = slot_q[rd_q];
	assign do_push = wr.push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wr.cmd;
		end
	end

endmodule

[design/hjn_back.sv]
// back end: hash table, chain walk, rate divider and result register
`timescale 1ns / 1ps
module hjn_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [hjn_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [63:0]                           cfg_data,
	input  logic                                  q_empty,
	input  hjn_pkg::cmd_t                         q_cmd,
	output logic                                  q_pop,
	output logic                                  init_busy,
	input  logic                                  pop,
	output logic                                  empty,
	output hjn_pkg::result_t                      result
);
	import hjn_pkg::*;

	logic [PTR_BITS-1:0]    head_mem  [NUM_BUCKETS];
	logic [PTR_BITS-1:0]    link_mem  [MAX_ENTRIES];
	logic [30:0]            id_mem    [MAX_ENTRIES];
	logic [63:0]            stamp_mem [MAX_ENTRIES];
	logic [63:0]            time_mem  [MAX_ENTRIES];
	logic [BUCKET_BITS-1:0] bkt_mem   [MAX_ENTRIES];

	back_state_e            state_q, state_d;
	logic [BUCKET_BITS-1:0] init_q;
	logic [PTR_BITS-1:0]    count_q;
	logic [39:0]            elapsed_q;
	logic                   snap_ok_q;
	cmd_t                   cmd_q;
	logic [PTR_BITS-1:0]    head_rd_q, link_rd_q, p_q;
	logic [BUCKET_BITS-1:0] bkt_rd_q;
	logic [30:0]            id_rd_q;
	logic [63:0]            stamp_rd_q, time_rd_q, delta_q;
	logic [68:0]            n25_q;
	logic [39:0]            rem_q;
	logic [23:0]            low_q, quo_q;
	logic [4:0]             dcnt_q;
	status_e                res_status_q;
	logic [23:0]            res_pct_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic [PTR_BITS-1:0]   head_m1, p_m1;
	logic                  head_ok, table_full, query_ok, match;
	logic [78:0]           num, lim;
	logic [40:0]           r2, r2_sub;
	logic                  ge;
	logic                  load_out;

	always_comb begin
		head_m1    = head_rd_q - {{(PTR_BITS-1){1'b0}}, 1'b1};
		p_m1       = p_q - {{(PTR_BITS-1){1'b0}}, 1'b1};
		head_ok    = (head_rd_q != '0) && (head_m1 < count_q) &&
		             (bkt_rd_q == cmd_q.bucket);
		table_full = (count_q == PTR_BITS'(MAX_ENTRIES));
		query_ok   = (cmd_q.item.start_stamp != 64'd0) && snap_ok_q && (elapsed_q != 40'd0);
		match      = (id_rd_q == cmd_q.item.process_id) &&
		             (stamp_rd_q == cmd_q.item.start_stamp);
		num        = {n25_q, 10'd0};
		lim        = {15'd0, elapsed_q, 24'd0};
		r2         = {rem_q, low_q[23]};
		r2_sub     = r2 - {1'b0, elapsed_q};
		ge         = (r2 >= {1'b0, elapsed_q});
		load_out   = (state_q == B_OUT) && (!out_valid_q || pop);
	end

	// registered reads
	always_ff @(posedge clk) begin
		head_rd_q  <= head_mem[cmd_q.bucket];
		bkt_rd_q   <= bkt_mem[head_m1[ENTRY_BITS-1:0]];
		link_rd_q  <= link_mem[p_m1[ENTRY_BITS-1:0]];
		id_rd_q    <= id_mem[p_m1[ENTRY_BITS-1:0]];
		stamp_rd_q <= stamp_mem[p_m1[ENTRY_BITS-1:0]];
		time_rd_q  <= time_mem[p_m1[ENTRY_BITS-1:0]];
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (state_q == B_INIT) begin
			head_mem[init_q] <= '0;
		end else if (state_q == B_HVAL && cmd_q.item.operation == OP_INSERT) begin
			head_mem[cmd_q.bucket]              <= count_q + {{(PTR_BITS-1){1'b0}}, 1'b1};
			link_mem[count_q[ENTRY_BITS-1:0]]   <= head_ok ? head_rd_q : '0;
			id_mem[count_q[ENTRY_BITS-1:0]]     <= cmd_q.item.process_id;
			stamp_mem[count_q[ENTRY_BITS-1:0]]  <= cmd_q.item.start_stamp;
			time_mem[count_q[ENTRY_BITS-1:0]]   <= cmd_q.item.cpu_time_ns;
			bkt_mem[count_q[ENTRY_BITS-1:0]]    <= cmd_q.bucket;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_INIT;
			init_q      <= '0;
			count_q     <= '0;
			elapsed_q   <= '0;
			snap_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_INIT) begin
				init_q <= init_q + {{(BUCKET_BITS-1){1'b0}}, 1'b1};
			end
			if (cfg_valid) begin
				if (cfg_index == REG_ELAPSED) begin
					elapsed_q <= cfg_data[39:0];
				end else if (cfg_index == REG_SNAPSHOTS) begin
					snap_ok_q <= cfg_data[0];
				end
			end
			if (state_q == B_HRD && cmd_q.item.operation == OP_CLEAR) begin
				count_q <= '0;
			end else if (state_q == B_HVAL && cmd_q.item.operation == OP_INSERT) begin
				count_q <= count_q + {{(PTR_BITS-1){1'b0}}, 1'b1};
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !q_empty) begin
			cmd_q <= q_cmd;
		end
		if (load_out) begin
			out_q <= '{status: res_status_q, cpu_percent_q8: res_pct_q};
		end
		case (state_q)
			B_HRD: begin
				res_pct_q <= '0;
				case (cmd_q.item.operation)
					OP_CLEAR:  res_status_q <= ST_CLEARED;
					OP_INSERT: res_status_q <= table_full ? ST_FULL : ST_STORED;
					default:   res_status_q <= ST_NO_RATE;
				endcase
			end
			B_HVAL: begin
				p_q <= head_ok ? head_rd_q : '0;
			end
			B_CMP: begin
				p_q     <= link_rd_q;
				delta_q <= cmd_q.item.cpu_time_ns - time_rd_q;
			end
			B_DSET: begin
				n25_q <= {1'b0, delta_q, 4'd0} + {2'd0, delta_q, 3'd0} + {5'd0, delta_q};
			end
			B_DSAT: begin
				rem_q        <= num[63:24];
				low_q        <= num[23:0];
				dcnt_q       <= 5'(DIV_STEPS - 1);
				res_status_q <= ST_RATE;
				res_pct_q    <= RATE_MAX;
			end
			B_DIV: begin
				rem_q  <= ge ? r2_sub[39:0] : r2[39:0];
				low_q  <= {low_q[22:0], 1'b0};
				quo_q  <= {quo_q[22:0], ge};
				dcnt_q <= dcnt_q - 5'd1;
				if (dcnt_q == 5'd0) begin
					res_pct_q <= {quo_q[22:0], ge};
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		init_busy = (state_q == B_INIT);
		empty     = !out_valid_q;
		result    = out_q;
		unique case (state_q)
			B_INIT: begin
				if (init_q == {BUCKET_BITS{1'b1}}) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_HRD;
				end
			end
			B_HRD: begin
				if (cmd_q.item.operation == OP_INSERT) begin
					state_d = table_full ? B_OUT : B_HCHK;
				end else if (cmd_q.item.operation == OP_QUERY) begin
					state_d = query_ok ? B_HCHK : B_OUT;
				end else begin
					state_d = B_OUT;
				end
			end
			B_HCHK: begin
				state_d = B_HVAL;
			end
			B_HVAL: begin
				state_d = (cmd_q.item.operation == OP_INSERT) ? B_OUT : B_WALK;
			end
			B_WALK: begin
				state_d = (p_q == '0) ? B_OUT : B_CMP;
			end
			B_CMP: begin
				if (match) begin
					state_d = (cmd_q.item.cpu_time_ns >= time_rd_q) ? B_DSET : B_OUT;
				end else begin
					state_d = B_WALK;
				end
			end
			B_DSET: begin
				state_d = B_DSAT;
			end
			B_DSAT: begin
				state_d = (num >= lim) ? B_OUT : B_DIV;
			end
			B_DIV: begin
				if (dcnt_q == 5'd0) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (!out_valid_q || pop) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

endmodule
